FILE: hdl/lkvc_pkg.sv
// Shared constants and command/status types for the LRU key-value cache.
package lkvc_pkg;

   localparam int LKVC_CAPACITY   = 16;
   localparam int LKVC_KEY_WIDTH  = 32;
   localparam int LKVC_DATA_W     = 32;
   localparam int LKVC_ACT_W      = 5;
   localparam int LKVC_CSR_ADDR_W = 3;
   localparam int LKVC_CSR_DATA_W = 32;

   localparam logic [LKVC_ACT_W-1:0] LKVC_ACT_RESET = 5'd16;

   // register index, taken from the word address bit of paddr
   localparam logic REG_ACTIVE_ENTRIES = 1'b0;

   typedef struct packed {
      logic load_req;   // latch the accepted request
      logic capture;    // register match, free and LRU search results
      logic fetch;      // read value memory, pick the operation
      logic commit;     // update the store and load the result register
   } lkvc_cmd_type;

   typedef struct packed {
      logic out_free;   // result register empty or being emptied
   } lkvc_sts_type;

endpackage

FILE: hdl/lkvc_if.sv
// Request and response channel interfaces of the LRU key-value cache.
interface lkvc_req_if import lkvc_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic signed [LKVC_DATA_W-1:0] lookup_key;
   logic signed [LKVC_DATA_W-1:0] write_value;

   modport source (output valid, req_type, lookup_key, write_value, input ready);
   modport sink   (input valid, req_type, lookup_key, write_value, output ready);
endinterface

interface lkvc_rsp_if import lkvc_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic signed [LKVC_DATA_W-1:0] read_value;
   logic                          evicted;
   logic signed [LKVC_DATA_W-1:0] evicted_key;

   modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
   modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

FILE: hdl/lkvc_ctrl.sv
// Sequencer for the LRU key-value cache: steps one request through match, fetch, commit.
module lkvc_ctrl import lkvc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  lkvc_sts_type sts,
   output lkvc_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_MATCH  = 4'b0010,
      ST_FETCH  = 4'b0100,
      ST_COMMIT = 4'b1000
   } lkvc_state_type;

   lkvc_state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.load_req = req_valid && req_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MATCH;
         end
         ST_MATCH: begin
            cmd.capture = 1'b1;
            state_in    = ST_FETCH;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_COMMIT;
         end
         ST_COMMIT: begin
            // hold until the result register can take the result
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/lkvc_datapath.sv
// Slot store, recency ranks, value memory and result register of the LRU key-value cache.
module lkvc_datapath import lkvc_pkg::*; #(
   parameter int CAPACITY  = LKVC_CAPACITY,
   parameter int KEY_WIDTH = LKVC_KEY_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lkvc_cmd_type                  cmd,
   output lkvc_sts_type                  sts,
   input  logic                          clear,
   input  logic [LKVC_ACT_W-1:0]         active_entries,
   input  logic                          req_type,
   input  logic signed [LKVC_DATA_W-1:0] lookup_key,
   input  logic signed [LKVC_DATA_W-1:0] write_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          hit,
   output logic signed [LKVC_DATA_W-1:0] read_value,
   output logic                          evicted,
   output logic signed [LKVC_DATA_W-1:0] evicted_key
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      OP_NONE    = 2'd0,
      OP_PROMOTE = 2'd1,
      OP_INSERT  = 2'd2,
      OP_EVICT   = 2'd3
   } lkvc_op_type;

   // request latch
   logic                   req_write_ff;
   logic [KEY_WIDTH-1:0]   req_key_ff;
   logic [LKVC_DATA_W-1:0] req_value_ff;

   // slot store
   logic [CAPACITY-1:0]    valid_ff;
   logic [KEY_WIDTH-1:0]   key_ff   [CAPACITY];
   logic [IDX_W-1:0]       age_ff   [CAPACITY];
   logic [CNT_W-1:0]       count_ff;
   logic [LKVC_DATA_W-1:0] value_ff [CAPACITY];
   logic [LKVC_DATA_W-1:0] rd_value_ff;

   // search results
   logic                   hit_ff;
   logic [IDX_W-1:0]       found_ff;
   logic [IDX_W-1:0]       lru_ff;
   logic [IDX_W-1:0]       free_ff;
   logic                   has_free_ff;

   // chosen operation
   lkvc_op_type            op_ff;
   logic [IDX_W-1:0]       target_ff;
   logic [IDX_W-1:0]       old_age_ff;
   logic [LKVC_DATA_W-1:0] victim_key_ff;

   // result register
   logic                   rsp_valid_ff;
   logic                   rsp_hit_ff;
   logic [LKVC_DATA_W-1:0] rsp_read_ff;
   logic                   rsp_evicted_ff;
   logic [LKVC_DATA_W-1:0] rsp_evicted_key_ff;

   logic [CAPACITY-1:0]    match_vec;
   logic [CAPACITY-1:0]    lru_vec;
   logic [CNT_W-1:0]       limit;

   function automatic logic [IDX_W-1:0] first_set(input logic [CAPACITY-1:0] v);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (v[i]) idx = IDX_W'(i);
      end
      return idx;
   endfunction

   // one comparator per slot; the LRU slot holds rank count-1
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         match_vec[i] = valid_ff[i] && (key_ff[i] == req_key_ff);
         lru_vec[i]   = valid_ff[i] && (CNT_W'(age_ff[i]) == count_ff - CNT_W'(1));
      end
   end

   // clamp the configured limit into 1..CAPACITY
   always_comb begin
      if (active_entries == '0) begin
         limit = CNT_W'(1);
      end else if (int'(active_entries) > CAPACITY) begin
         limit = CNT_W'(CAPACITY);
      end else begin
         limit = CNT_W'(active_entries);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_write_ff <= req_type;
         req_key_ff   <= KEY_WIDTH'($unsigned(lookup_key));
         req_value_ff <= $unsigned(write_value);
      end
      if (cmd.capture) begin
         hit_ff      <= |match_vec;
         found_ff    <= first_set(match_vec);
         lru_ff      <= first_set(lru_vec);
         free_ff     <= first_set(~valid_ff);
         has_free_ff <= ~&valid_ff;
      end
      if (cmd.fetch) begin
         victim_key_ff <= LKVC_DATA_W'(key_ff[lru_ff]);
         if (hit_ff) begin
            op_ff      <= OP_PROMOTE;
            target_ff  <= found_ff;
            old_age_ff <= age_ff[found_ff];
         end else if (!req_write_ff) begin
            op_ff      <= OP_NONE;
            target_ff  <= lru_ff;
            old_age_ff <= age_ff[lru_ff];
         end else if ((count_ff < limit) && has_free_ff) begin
            op_ff      <= OP_INSERT;
            target_ff  <= free_ff;
            old_age_ff <= age_ff[lru_ff];
         end else begin
            op_ff      <= OP_EVICT;
            target_ff  <= lru_ff;
            old_age_ff <= age_ff[lru_ff];
         end
      end
   end

   // value memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         rd_value_ff <= value_ff[found_ff];
      end
      if (cmd.commit && req_write_ff && (op_ff != OP_NONE)) begin
         value_ff[target_ff] <= req_value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && ((op_ff == OP_INSERT) || (op_ff == OP_EVICT))) begin
         key_ff[target_ff] <= req_key_ff;
      end
   end

   // recency ranks, valid bits and fill count
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < CAPACITY; i++) begin
            age_ff[i] <= '0;
         end
      end else if (cmd.commit) begin
         case (op_ff)
            OP_PROMOTE, OP_EVICT: begin
               for (int i = 0; i < CAPACITY; i++) begin
                  if (valid_ff[i] && (IDX_W'(i) != target_ff) && (age_ff[i] < old_age_ff))
                     age_ff[i] <= age_ff[i] + IDX_W'(1);
               end
               age_ff[target_ff] <= '0;
            end
            OP_INSERT: begin
               for (int i = 0; i < CAPACITY; i++) begin
                  if (valid_ff[i]) age_ff[i] <= age_ff[i] + IDX_W'(1);
               end
               age_ff[target_ff]   <= '0;
               valid_ff[target_ff] <= 1'b1;
               count_ff            <= count_ff + CNT_W'(1);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff         <= hit_ff;
         rsp_read_ff        <= (hit_ff && !req_write_ff) ? rd_value_ff : '0;
         rsp_evicted_ff     <= (op_ff == OP_EVICT);
         rsp_evicted_key_ff <= (op_ff == OP_EVICT) ? victim_key_ff : '0;
      end
   end

   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign hit          = rsp_hit_ff;
   assign read_value   = $signed(rsp_read_ff);
   assign evicted      = rsp_evicted_ff;
   assign evicted_key  = $signed(rsp_evicted_key_ff);

   a_count_tracks_valid: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'($countones(valid_ff)))
      else $error("fill count out of step with valid bits");

   a_keys_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("key present in more than one slot");

   a_insert_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && (op_ff == OP_INSERT) |-> !valid_ff[target_ff])
      else $error("insert into an occupied slot");

   a_evict_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && (op_ff == OP_EVICT) |-> (count_ff != '0))
      else $error("eviction from an empty store");

   a_commit_loads_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed request left no result");

endmodule

FILE: hdl/lru_key_value_cache.sv
// Top level of the LRU key-value cache: channels, control register and submodules.
//
//   channel   direction  handshake        carries
//   req_chan  in         valid/ready      req_type, lookup_key, write_value
//   rsp_chan  out        valid/ready      hit, read_value, evicted, evicted_key
//   apb       in         psel/penable     active_entries (byte address 0)
//
// A request steps from transfer to result through match, fetch and commit; the result
// is valid right after the commit edge and the sequencer is back in idle. The four states
// take one request at a time: idle takes the transfer, and no new one is accepted until commit.
// The result register lets the next request transfer while a result waits; a stalled
// result holds the sequencer in its commit step, with no state touched.
// Reset (synchronous) empties the store and sets active_entries to 16; writing
// active_entries also empties the store, in the same cycle.
module lru_key_value_cache import lkvc_pkg::*; #(
   parameter int CAPACITY  = LKVC_CAPACITY,
   parameter int KEY_WIDTH = LKVC_KEY_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   lkvc_req_if.sink                   req_chan,
   lkvc_rsp_if.source                 rsp_chan,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [LKVC_CSR_ADDR_W-1:0] paddr,
   input  logic [LKVC_CSR_DATA_W-1:0] pwdata,
   output logic [LKVC_CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   lkvc_cmd_type          cmd;
   lkvc_sts_type          sts;
   logic [LKVC_ACT_W-1:0] active_entries_ff;
   logic                  cfg_write;

   // Control register. Bit 2 of paddr picks the word; the byte offset is ignored.
   // A write to the limit register also clears the store.
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_ACTIVE_ENTRIES);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_entries_ff <= LKVC_ACT_RESET;
      end else if (cfg_write) begin
         active_entries_ff <= pwdata[LKVC_ACT_W-1:0];
      end
   end

   always_comb begin
      if (paddr[2] == REG_ACTIVE_ENTRIES) begin
         prdata = LKVC_CSR_DATA_W'(active_entries_ff);
      end else begin
         prdata = '0;
      end
   end

   // Sequencer: accepts one request, then steps it through match, fetch and commit.
   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: per-slot comparators, recency ranks, value memory, result register.
   lkvc_datapath #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .clear          (cfg_write),
      .active_entries (active_entries_ff),
      .req_type       (req_chan.req_type),
      .lookup_key     (req_chan.lookup_key),
      .write_value    (req_chan.write_value),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .hit            (rsp_chan.hit),
      .read_value     (rsp_chan.read_value),
      .evicted        (rsp_chan.evicted),
      .evicted_key    (rsp_chan.evicted_key)
   );

endmodule

FILE: bench/lru_key_value_cache_test.sv
// Self-checking testbench for the LRU key-value cache: requests, response checks, APB setup.
`timescale 1ns / 1ps

module lru_key_value_cache_test;
   import lkvc_pkg::*;

   localparam int SLOTS        = LKVC_CAPACITY;
   localparam int PHASE_ITEMS  = 128;
   localparam int SETTLE_TICKS = 8;        // cover the four-step sequencer plus margin
   localparam int CYCLE_LIMIT  = 250000;   // ~1400 items with their idle gaps and response stalls, many times over
   localparam logic [LKVC_CSR_ADDR_W-1:0] ACTIVE_ENTRIES_ADDR = {REG_ACTIVE_ENTRIES, 2'b00};

   typedef struct packed {
      logic                          is_write;
      logic signed [LKVC_DATA_W-1:0] key;
      logic signed [LKVC_DATA_W-1:0] data;
   } cache_req_type;

   typedef struct packed {
      logic                          hit;
      logic signed [LKVC_DATA_W-1:0] read_value;
      logic                          evicted;
      logic signed [LKVC_DATA_W-1:0] evicted_key;
   } cache_reply_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       psel;
   logic                       penable;
   logic                       pwrite;
   logic [LKVC_CSR_ADDR_W-1:0] paddr;
   logic [LKVC_CSR_DATA_W-1:0] pwdata;
   logic [LKVC_CSR_DATA_W-1:0] prdata;
   logic                       pready;

   lkvc_req_if req_bus ();
   lkvc_rsp_if rsp_bus ();

   lru_key_value_cache u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Requests waiting to be driven, and replies expected in transfer order.
   cache_req_type   pending_q[$];
   cache_reply_type reply_q[$];

   int error_count = 0;
   int cycle_count = 0;

   // Shadow of the cache contents: occupancy, key, value and recency rank
   // (rank 0 is the most recent entry).
   logic                          shadow_used [SLOTS];
   logic signed [LKVC_DATA_W-1:0] shadow_key  [SLOTS];
   logic signed [LKVC_DATA_W-1:0] shadow_data [SLOTS];
   int                            shadow_rank [SLOTS];
   logic [LKVC_ACT_W-1:0]         entry_cap;

   // Run-length state for idle draws: a nonzero count forces back-to-back transfers.
   int req_burst_left = 0;
   int rsp_burst_left = 0;

   task automatic report_mismatch(string what);
      error_count++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   // Draw an idle count of 0..5, with occasional stretches of no idling at all.
   function automatic int draw_wait(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0)
         burst_left = $urandom_range(10, 40);
      return $urandom_range(0, 5);
   endfunction

   function automatic void empty_shadow();
      int i;
      for (i = 0; i < SLOTS; i++) begin
         shadow_used[i] = 1'b0;
         shadow_key[i]  = '0;
         shadow_data[i] = '0;
         shadow_rank[i] = 0;
      end
   endfunction

   // Move slot s to the front; entries that were more recent than it age by one.
   function automatic void make_newest(int s);
      int i;
      int old_rank;
      old_rank = shadow_rank[s];
      for (i = 0; i < SLOTS; i++)
         if (shadow_used[i] && i != s && shadow_rank[i] < old_rank)
            shadow_rank[i]++;
      shadow_rank[s] = 0;
   endfunction

   // Apply one request to the shadow and return the reply the cache must give.
   function automatic cache_reply_type predict_reply(cache_req_type rq);
      cache_reply_type rp;
      int i;
      int used;
      int limit;
      int hit_slot;
      int free_slot;
      int lru_slot;
      rp        = '0;
      used      = 0;
      hit_slot  = -1;
      free_slot = -1;
      lru_slot  = -1;
      // zero behaves as one, anything past the slot count as the slot count
      if (entry_cap == 0)
         limit = 1;
      else if (int'(entry_cap) > SLOTS)
         limit = SLOTS;
      else
         limit = int'(entry_cap);

      for (i = 0; i < SLOTS; i++) begin
         if (shadow_used[i]) begin
            used++;
            if (hit_slot < 0 && shadow_key[i] == rq.key)
               hit_slot = i;
            if (lru_slot < 0 || shadow_rank[i] > shadow_rank[lru_slot])
               lru_slot = i;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end

      if (hit_slot >= 0) begin
         rp.hit = 1'b1;
         if (rq.is_write)
            shadow_data[hit_slot] = rq.data;
         else
            rp.read_value = shadow_data[hit_slot];
         make_newest(hit_slot);
      end else if (rq.is_write) begin
         if (used < limit && free_slot >= 0) begin
            // fill the lowest free slot; every resident entry ages
            for (i = 0; i < SLOTS; i++)
               if (shadow_used[i])
                  shadow_rank[i]++;
            shadow_used[free_slot] = 1'b1;
            shadow_key[free_slot]  = rq.key;
            shadow_data[free_slot] = rq.data;
            shadow_rank[free_slot] = 0;
         end else if (lru_slot >= 0) begin
            // replace the least recent entry and report its key
            rp.evicted            = 1'b1;
            rp.evicted_key        = shadow_key[lru_slot];
            shadow_key[lru_slot]  = rq.key;
            shadow_data[lru_slot] = rq.data;
            make_newest(lru_slot);
         end
      end
      return rp;
   endfunction

   function automatic void push_item(logic is_write, logic [31:0] key, logic [31:0] data);
      cache_req_type rq;
      rq.is_write = is_write;
      rq.key      = key;
      rq.data     = data;
      pending_q.push_back(rq);
   endfunction

   // Request driver: hold each item until its transfer, then idle for a drawn count.
   int            req_gap_left;
   cache_req_type drive_item;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid       <= 1'b0;
         req_bus.req_type    <= 1'b0;
         req_bus.lookup_key  <= '0;
         req_bus.write_value <= '0;
         req_gap_left = 0;
      end else begin
         // predict on the transfer, while the accepted fields are still on the bus
         if (req_bus.valid && req_bus.ready) begin
            drive_item.is_write = req_bus.req_type;
            drive_item.key      = req_bus.lookup_key;
            drive_item.data     = req_bus.write_value;
            reply_q.push_back(predict_reply(drive_item));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap_left > 0) begin
               req_gap_left--;
               req_bus.valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               drive_item = pending_q.pop_front();
               req_bus.valid       <= 1'b1;
               req_bus.req_type    <= drive_item.is_write;
               req_bus.lookup_key  <= drive_item.key;
               req_bus.write_value <= drive_item.data;
               req_gap_left = draw_wait(req_burst_left);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check each transfer against the oldest prediction, then
   // stall ready for a drawn count.
   int              rsp_stall_left;
   cache_reply_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (reply_q.size() == 0) begin
               report_mismatch("response transfer with no request outstanding");
            end else begin
               want = reply_q.pop_front();
               if (rsp_bus.hit !== want.hit)
                  report_mismatch($sformatf("hit got %b want %b", rsp_bus.hit, want.hit));
               if (rsp_bus.read_value !== want.read_value)
                  report_mismatch($sformatf("read_value got %0d want %0d",
                                            rsp_bus.read_value, want.read_value));
               if (rsp_bus.evicted !== want.evicted)
                  report_mismatch($sformatf("evicted got %b want %b",
                                            rsp_bus.evicted, want.evicted));
               if (rsp_bus.evicted_key !== want.evicted_key)
                  report_mismatch($sformatf("evicted_key got %0d want %0d",
                                            rsp_bus.evicted_key, want.evicted_key));
            end
            rsp_stall_left = draw_wait(rsp_burst_left);
         end
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog: abort a run that hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Block until every queued item has transferred and every reply has come back,
   // then let the sequencer drain back to idle.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_q.size() != 0 || req_bus.valid || reply_q.size() != 0);
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   // APB write of active_entries: setup cycle, then access until pready.
   // The cache empties itself on this write, so the shadow does the same.
   task automatic write_active_entries(logic [LKVC_ACT_W-1:0] setting);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ACTIVE_ENTRIES_ADDR;
      pwdata  <= LKVC_CSR_DATA_W'(setting);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock);
      while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      entry_cap = setting;
      empty_shadow();
   endtask

   // Random phase: mostly keys from a small pool so lookups hit and writes
   // both refresh and evict; the rest are fresh keys that miss.
   task automatic queue_random_phase(int count);
      logic [31:0] key_pool[24];
      int pool_n;
      int n;
      int k;
      logic [31:0] key;
      pool_n = (entry_cap == 0) ? 3 : int'(entry_cap) + $urandom_range(1, 6);
      if (pool_n > 24)
         pool_n = 24;
      for (k = 0; k < pool_n; k++)
         key_pool[k] = $urandom;
      for (n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) == 0)
            key = $urandom;
         else
            key = key_pool[$urandom_range(0, pool_n - 1)];
         push_item($urandom_range(0, 99) < 45, key, $urandom);
      end
   endtask

   logic [LKVC_ACT_W-1:0] phase_caps[11] = '{5'd31, 5'd16, 5'd1, 5'd3, 5'd5, 5'd8,
                                             5'd0, 5'd12, 5'd2, 5'd17, 5'd4};

   initial begin
      int p;
      // hold the control inputs at a known value from time zero
      reset               <= 1'b1;
      psel                <= 1'b0;
      penable             <= 1'b0;
      pwrite              <= 1'b0;
      paddr               <= '0;
      pwdata              <= '0;
      entry_cap = LKVC_ACT_RESET;
      empty_shadow();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset limit of 16: extreme keys and values, a miss, a hit,
      // a rewrite of a present key, and a lookup of the rewritten value.
      push_item(1'b1, 32'h8000_0000, 32'h7fff_ffff);
      push_item(1'b1, 32'h7fff_ffff, 32'h8000_0000);
      push_item(1'b1, 32'h0000_0000, 32'h0000_0000);
      push_item(1'b1, 32'hffff_ffff, 32'hffff_ffff);
      push_item(1'b0, 32'h8000_0000, 32'h5555_5555);
      push_item(1'b0, 32'h0000_0005, 32'haaaa_aaaa);
      push_item(1'b1, 32'h7fff_ffff, 32'h1234_5678);
      push_item(1'b0, 32'h7fff_ffff, 32'h0000_0000);
      wait_idle();

      // Limit of two: fill, evict the oldest, miss on it, promote, evict again.
      write_active_entries(5'd2);
      push_item(1'b1, 32'd1, 32'd101);
      push_item(1'b1, 32'd2, 32'd102);
      push_item(1'b1, 32'd3, 32'd103);
      push_item(1'b0, 32'd1, 32'd0);
      push_item(1'b0, 32'd2, 32'd0);
      push_item(1'b1, 32'd4, 32'd104);
      wait_idle();

      // Zero limit acts as one: every new key evicts the previous one.
      write_active_entries(5'd0);
      push_item(1'b1, 32'd7, 32'hdead_beef);
      push_item(1'b1, 32'd8, 32'hcafe_f00d);
      push_item(1'b0, 32'd8, 32'd0);
      wait_idle();

      // Random phases across the limit range, extremes included.
      for (p = 0; p < 11; p++) begin
         write_active_entries(phase_caps[p]);
         queue_random_phase(PHASE_ITEMS);
         wait_idle();
      end

      if (error_count == 0 && reply_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: files.f
hdl/lkvc_pkg.sv
hdl/lkvc_if.sv
hdl/lkvc_ctrl.sv
hdl/lkvc_datapath.sv
hdl/lru_key_value_cache.sv
bench/lru_key_value_cache_test.sv
